// ===== rtl/vsgm_pkg.sv =====
// Shared types and constants for the voxel slice greedy mesher.
package vsgm_pkg;

    // Request kinds
    localparam logic [1:0] REQ_FILL  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;
    localparam logic [1:0] REQ_MESH  = 2'd3;

    localparam logic [2:0] FACE_MAX = 3'd5;

    // Per face direction: normal axis, positive flag, u axis, v axis
    typedef struct packed {
        logic [1:0] ax;
        logic       pos;
        logic [1:0] ua;
        logic [1:0] va;
    } dir_t;

    localparam dir_t DIR_TAB [8] = '{
        '{2'd0, 1'b1, 2'd1, 2'd2},
        '{2'd0, 1'b0, 2'd1, 2'd2},
        '{2'd1, 1'b1, 2'd2, 2'd0},
        '{2'd1, 1'b0, 2'd2, 2'd0},
        '{2'd2, 1'b1, 2'd0, 2'd1},
        '{2'd2, 1'b0, 2'd0, 2'd1},
        '{2'd0, 1'b0, 2'd1, 2'd2},
        '{2'd0, 1'b0, 2'd1, 2'd2}
    };

    // One result word
    typedef struct packed {
        logic [7:0] read_id;
        logic [7:0] read_data;
        logic       range_error;
        logic       quad_valid;
        logic [2:0] quad_face;
        logic [3:0] quad_plane;
        logic [2:0] start_u;
        logic [2:0] start_v;
        logic [3:0] extent_u;
        logic [3:0] extent_v;
        logic [7:0] quad_block;
        logic       last;
    } res_t;

    // Place normal, u and v coordinates onto x, y, z
    function automatic logic [2:0][2:0] place(input dir_t d, input logic [2:0] n,
                                              input logic [2:0] u, input logic [2:0] v);
        logic [2:0][2:0] c;
        c = '0;
        c[d.ax] = n;
        c[d.ua] = u;
        c[d.va] = v;
        return c;
    endfunction

endpackage

// ===== rtl/vsgm_store.sv =====
// Voxel id and data memory, single port with registered read.
module vsgm_store #(
    parameter int DEPTH = 512,
    parameter int AW    = 9
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] addr,
    input  logic [7:0]    wid,
    input  logic [7:0]    wdat,
    output logic [7:0]    qid,
    output logic [7:0]    qdat
);

    logic [7:0] id_mem   [DEPTH];
    logic [7:0] data_mem [DEPTH];

    // write, then registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            id_mem[addr]   <= wid;
            data_mem[addr] <= wdat;
        end
        qid  <= id_mem[addr];
        qdat <= data_mem[addr];
    end

endmodule

// ===== rtl/vsgm_mask.sv =====
// Face mask memory for one slice, single port with registered read.
module vsgm_mask #(
    parameter int DEPTH = 64,
    parameter int MW    = 6
) (
    input  logic          clk,
    input  logic          we,
    input  logic [MW-1:0] addr,
    input  logic [7:0]    wid,
    output logic [7:0]    qid
);

    logic [7:0] mask_mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mask_mem[addr] <= wid;
        end
        qid <= mask_mem[addr];
    end

endmodule

// ===== rtl/voxel_slice_greedy_mesher_unit.sv =====
// Top level: request sequencer driving the voxel store, face mask and merge scan.
// A mesh request builds the face mask, then scans each mask cell, probing the mask to grow a
// rectangle of equal ids and clearing each merged cell before the quad is emitted.
// Throughput: one request at a time; the single store port and mask port set the pace.
// Reset: rst_n clears control state, then a clearing pass over every address zeroes the store
// before the first word is accepted.
module voxel_slice_greedy_mesher_unit #(
    parameter int SIDE = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // pos_x, pos_y, pos_z, voxel_id, voxel_data, face_dir, slice_index, zero pad
    input  logic [55:0] s_axis_tdata,
    // req_type
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // read_id, read_data, range_error, quad_valid, quad_face, quad_plane, start_u,
    // start_v, extent_u, extent_v, quad_block, zero pad
    output logic [47:0] m_axis_tdata,
    output logic        m_axis_tlast
);

    localparam int DEPTH = SIDE * SIDE * SIDE;
    localparam int AW    = $clog2(DEPTH);
    localparam int PLANE = SIDE * SIDE;
    localparam int MW    = $clog2(PLANE);

    typedef enum logic [20:0] {
        ST_CLR  = 21'h000001,
        ST_IDLE = 21'h000002,
        ST_FILL = 21'h000004,
        ST_WR   = 21'h000008,
        ST_RD_W = 21'h000010,
        ST_RD_C = 21'h000020,
        ST_RES  = 21'h000040,
        ST_B_C  = 21'h000080,
        ST_B_N  = 21'h000100,
        ST_B_W  = 21'h000200,
        ST_SC_W = 21'h000400,
        ST_SC_C = 21'h000800,
        ST_GV_W = 21'h001000,
        ST_GV_C = 21'h002000,
        ST_GU_I = 21'h004000,
        ST_GU_W = 21'h008000,
        ST_GU_C = 21'h010000,
        ST_MARK = 21'h020000,
        ST_EMIT = 21'h040000,
        ST_NEXT = 21'h080000,
        ST_M0   = 21'h100000
    } state_t;

    state_t state_reg, state_next;
    logic [AW-1:0] cnt_reg, cnt_next;
    logic [2:0] face_reg, face_next, d_reg, d_next;
    logic [2:0] x_reg, x_next, y_reg, y_next, z_reg, z_next;
    logic [7:0] id_reg, id_next, dat_reg, dat_next;
    logic [2:0] su_reg, su_next, sv_reg, sv_next, pu_reg, pu_next, pv_reg, pv_next;
    logic [2:0] k_reg, k_next;
    logic [3:0] du_reg, du_next, dv_reg, dv_next;
    logic [7:0] cid_reg, cid_next, idr_reg, idr_next;
    vsgm_pkg::res_t res_reg, res_next, pend_reg, pend_next, out_reg, out_next;
    logic pend_v_reg, pend_v_next, out_v_reg, out_v_next;

    // store and mask ports
    logic          st_we, mk_we;
    logic [AW-1:0] st_addr;
    logic [MW-1:0] mk_addr;
    logic [7:0]    st_wid, st_wdat, st_qid, st_qdat, mk_wid, mk_qid;

    vsgm_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
        .clk (clk), .we (st_we), .addr (st_addr), .wid (st_wid), .wdat (st_wdat),
        .qid (st_qid), .qdat (st_qdat)
    );

    vsgm_mask #(.DEPTH(PLANE), .MW(MW)) u_mask (
        .clk (clk), .we (mk_we), .addr (mk_addr), .wid (mk_wid), .qid (mk_qid)
    );

    // input word unpack
    logic [1:0] in_req;
    logic [7:0] in_x, in_y, in_z, in_id, in_dat, in_slice;
    logic [2:0] in_face;
    logic       in_bad, in_acc;
    assign in_req   = s_axis_tuser;
    assign in_x     = s_axis_tdata[7:0];
    assign in_y     = s_axis_tdata[15:8];
    assign in_z     = s_axis_tdata[23:16];
    assign in_id    = s_axis_tdata[31:24];
    assign in_dat   = s_axis_tdata[39:32];
    assign in_face  = s_axis_tdata[42:40];
    assign in_slice = s_axis_tdata[50:43];
    assign in_bad   = (in_x >= 8'(SIDE)) || (in_y >= 8'(SIDE)) || (in_z >= 8'(SIDE));
    assign in_acc   = s_axis_tvalid && s_axis_tready;

    assign s_axis_tready = (state_reg == ST_IDLE);

    // output word
    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tlast  = out_reg.last;
    assign m_axis_tdata  = {1'b0, out_reg.quad_block, out_reg.extent_v, out_reg.extent_u,
                            out_reg.start_v, out_reg.start_u, out_reg.quad_plane,
                            out_reg.quad_face, out_reg.quad_valid, out_reg.range_error,
                            out_reg.read_data, out_reg.read_id};

    // slice geometry
    vsgm_pkg::dir_t  dir;
    logic [2:0]      nb;
    logic            at_edge;
    logic [2:0][2:0] cc;
    logic [3:0]      plane;
    assign dir     = vsgm_pkg::DIR_TAB[face_reg];
    assign nb      = dir.pos ? d_reg + 3'd1 : d_reg - 3'd1;
    assign at_edge = dir.pos ? (d_reg == 3'(SIDE - 1)) : (d_reg == 3'd0);
    assign plane   = dir.pos ? {1'b0, d_reg} + 4'd1 : {1'b0, d_reg};

    // store address
    always_comb
    begin
        cc = '0;
        priority if (state_reg == ST_B_C)
        begin
            cc = vsgm_pkg::place(dir, d_reg, su_reg, sv_reg);
        end
        else if (state_reg == ST_B_N)
        begin
            cc = vsgm_pkg::place(dir, nb, su_reg, sv_reg);
        end
        else
        begin
            cc[0] = x_reg;
            cc[1] = y_reg;
            cc[2] = z_reg;
        end
        if (state_reg == ST_CLR || state_reg == ST_FILL)
        begin
            st_addr = cnt_reg;
        end
        else
        begin
            st_addr = AW'(cc[0]) * AW'(SIDE * SIDE) + AW'(cc[1]) * AW'(SIDE) + AW'(cc[2]);
        end
    end

    assign st_we   = (state_reg == ST_CLR) || (state_reg == ST_FILL) || (state_reg == ST_WR);
    assign st_wid  = (state_reg == ST_CLR) ? 8'd0 : id_reg;
    assign st_wdat = (state_reg == ST_CLR) ? 8'd0 : dat_reg;

    // mask port: written at the scan cell while building, cleared at the probe cell
    // once merged (a zero entry counts as merged), read at the probe cell otherwise
    logic [MW-1:0] su_addr, pr_addr;
    assign su_addr = MW'(su_reg) * MW'(SIDE) + MW'(sv_reg);
    assign pr_addr = MW'(pu_reg) * MW'(SIDE) + MW'(pv_reg);
    assign mk_we   = (state_reg == ST_B_W) || (state_reg == ST_MARK);
    assign mk_addr = (state_reg == ST_B_W) ? su_addr : pr_addr;
    assign mk_wid  = (state_reg == ST_MARK) ? 8'd0 :
                     ((at_edge || st_qid == 8'd0) ? cid_reg : 8'd0);

    // probe test against the current run
    logic probe_ok;
    assign probe_ok = (mk_qid == idr_reg);

    // quad for the rectangle just grown
    vsgm_pkg::res_t new_quad;
    always_comb
    begin
        new_quad            = '0;
        new_quad.quad_valid = 1'b1;
        new_quad.quad_face  = face_reg;
        new_quad.quad_plane = plane;
        new_quad.start_u    = su_reg;
        new_quad.start_v    = sv_reg;
        new_quad.extent_u   = du_reg;
        new_quad.extent_v   = dv_reg;
        new_quad.quad_block = idr_reg;
    end

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        face_next   = face_reg;
        d_next      = d_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        z_next      = z_reg;
        id_next     = id_reg;
        dat_next    = dat_reg;
        su_next     = su_reg;
        sv_next     = sv_reg;
        pu_next     = pu_reg;
        pv_next     = pv_reg;
        k_next      = k_reg;
        du_next     = du_reg;
        dv_next     = dv_reg;
        cid_next    = cid_reg;
        idr_next    = idr_reg;
        res_next    = res_reg;
        pend_next   = pend_reg;
        pend_v_next = pend_v_reg;
        out_next    = out_reg;
        out_v_next  = out_v_reg;

        if (out_v_reg && m_axis_tready)
        begin
            out_v_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLR:
            begin
                cnt_next = cnt_reg + AW'(1);
                if (cnt_reg == AW'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    x_next        = in_x[2:0];
                    y_next        = in_y[2:0];
                    z_next        = in_z[2:0];
                    id_next       = in_id;
                    dat_next      = in_dat;
                    face_next     = in_face;
                    d_next        = in_slice[2:0];
                    res_next      = '0;
                    res_next.last = 1'b1;
                    cnt_next      = '0;
                    su_next       = '0;
                    sv_next       = '0;
                    unique case (in_req)
                        vsgm_pkg::REQ_FILL:
                        begin
                            state_next = ST_FILL;
                        end
                        vsgm_pkg::REQ_WRITE:
                        begin
                            res_next.range_error = in_bad;
                            state_next = in_bad ? ST_RES : ST_WR;
                        end
                        vsgm_pkg::REQ_READ:
                        begin
                            res_next.range_error = in_bad;
                            state_next = in_bad ? ST_RES : ST_RD_W;
                        end
                        vsgm_pkg::REQ_MESH:
                        begin
                            if (in_slice >= 8'(SIDE) || in_face > vsgm_pkg::FACE_MAX)
                            begin
                                res_next.range_error = 1'b1;
                                state_next = ST_RES;
                            end
                            else
                            begin
                                state_next = ST_B_C;
                            end
                        end
                        default:
                        begin
                            state_next = ST_RES;
                        end
                    endcase
                end
            end
            ST_FILL:
            begin
                cnt_next = cnt_reg + AW'(1);
                if (cnt_reg == AW'(DEPTH - 1))
                begin
                    state_next = ST_RES;
                end
            end
            ST_WR:
            begin
                state_next = ST_RES;
            end
            ST_RD_W:
            begin
                state_next = ST_RD_C;
            end
            ST_RD_C:
            begin
                res_next.read_id   = st_qid;
                res_next.read_data = st_qdat;
                state_next = ST_RES;
            end
            ST_RES:
            begin
                if (!out_v_reg)
                begin
                    out_next   = res_reg;
                    out_v_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            // mask build: cell read, neighbor read, mask write
            ST_B_C:
            begin
                state_next = ST_B_N;
            end
            ST_B_N:
            begin
                cid_next   = st_qid;
                state_next = ST_B_W;
            end
            ST_B_W:
            begin
                if (sv_reg == 3'(SIDE - 1))
                begin
                    sv_next = '0;
                    su_next = su_reg + 3'd1;
                    if (su_reg == 3'(SIDE - 1))
                    begin
                        state_next = ST_M0;
                    end
                    else
                    begin
                        state_next = ST_B_C;
                    end
                end
                else
                begin
                    sv_next    = sv_reg + 3'd1;
                    state_next = ST_B_C;
                end
            end
            ST_M0:
            begin
                su_next     = '0;
                sv_next     = '0;
                pu_next     = '0;
                pv_next     = '0;
                pend_v_next = 1'b0;
                state_next  = ST_SC_W;
            end
            // merge scan
            ST_SC_W:
            begin
                state_next = ST_SC_C;
            end
            ST_SC_C:
            begin
                if (mk_qid == 8'd0)
                begin
                    state_next = ST_NEXT;
                end
                else
                begin
                    idr_next = mk_qid;
                    dv_next  = 4'd1;
                    du_next  = 4'd1;
                    if ({1'b0, sv_reg} + 4'd1 < 4'(SIDE))
                    begin
                        pv_next    = sv_reg + 3'd1;
                        state_next = ST_GV_W;
                    end
                    else
                    begin
                        state_next = ST_GU_I;
                    end
                end
            end
            ST_GV_W:
            begin
                state_next = ST_GV_C;
            end
            ST_GV_C:
            begin
                if (probe_ok)
                begin
                    dv_next = dv_reg + 4'd1;
                    if ({1'b0, pv_reg} + 4'd1 < 4'(SIDE))
                    begin
                        pv_next    = pv_reg + 3'd1;
                        state_next = ST_GV_W;
                    end
                    else
                    begin
                        state_next = ST_GU_I;
                    end
                end
                else
                begin
                    state_next = ST_GU_I;
                end
            end
            ST_GU_I:
            begin
                if ({1'b0, su_reg} + du_reg < 4'(SIDE))
                begin
                    pu_next    = 3'({1'b0, su_reg} + du_reg);
                    pv_next    = sv_reg;
                    k_next     = '0;
                    state_next = ST_GU_W;
                end
                else
                begin
                    pu_next    = su_reg;
                    pv_next    = sv_reg;
                    state_next = ST_MARK;
                end
            end
            ST_GU_W:
            begin
                state_next = ST_GU_C;
            end
            ST_GU_C:
            begin
                if (!probe_ok)
                begin
                    pu_next    = su_reg;
                    pv_next    = sv_reg;
                    state_next = ST_MARK;
                end
                else if ({1'b0, k_reg} + 4'd1 < dv_reg)
                begin
                    k_next     = k_reg + 3'd1;
                    pv_next    = pv_reg + 3'd1;
                    state_next = ST_GU_W;
                end
                else
                begin
                    du_next    = du_reg + 4'd1;
                    state_next = ST_GU_I;
                end
            end
            // clear the merged rectangle in the mask, one cell per cycle
            ST_MARK:
            begin
                if ({1'b0, pv_reg} + 4'd1 < {1'b0, sv_reg} + dv_reg)
                begin
                    pv_next = pv_reg + 3'd1;
                end
                else
                begin
                    pv_next = sv_reg;
                    if ({1'b0, pu_reg} + 4'd1 < {1'b0, su_reg} + du_reg)
                    begin
                        pu_next = pu_reg + 3'd1;
                    end
                    else
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            // hold one quad back so the final one can carry last
            ST_EMIT:
            begin
                if (!pend_v_reg)
                begin
                    pend_next   = new_quad;
                    pend_v_next = 1'b1;
                    state_next  = ST_NEXT;
                end
                else if (!out_v_reg)
                begin
                    out_next    = pend_reg;
                    out_v_next  = 1'b1;
                    pend_next   = new_quad;
                    state_next  = ST_NEXT;
                end
            end
            ST_NEXT:
            begin
                if (sv_reg == 3'(SIDE - 1))
                begin
                    sv_next = '0;
                    pv_next = '0;
                    su_next = su_reg + 3'd1;
                    pu_next = su_reg + 3'd1;
                    if (su_reg == 3'(SIDE - 1))
                    begin
                        res_next      = pend_v_reg ? pend_reg : '0;
                        res_next.last = 1'b1;
                        state_next    = ST_RES;
                    end
                    else
                    begin
                        state_next = ST_SC_W;
                    end
                end
                else
                begin
                    sv_next    = sv_reg + 3'd1;
                    pv_next    = sv_reg + 3'd1;
                    pu_next    = su_reg;
                    state_next = ST_SC_W;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLR;
            cnt_reg    <= '0;
            pend_v_reg <= 1'b0;
            out_v_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            pend_v_reg <= pend_v_next;
            out_v_reg  <= out_v_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        face_reg <= face_next;
        d_reg    <= d_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        id_reg   <= id_next;
        dat_reg  <= dat_next;
        su_reg   <= su_next;
        sv_reg   <= sv_next;
        pu_reg   <= pu_next;
        pv_reg   <= pv_next;
        k_reg    <= k_next;
        du_reg   <= du_next;
        dv_reg   <= dv_next;
        cid_reg  <= cid_next;
        idr_reg  <= idr_next;
        res_reg  <= res_next;
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

    // checks
    a_quad_extent: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && out_reg.quad_valid) |-> (out_reg.extent_u != 4'd0 &&
                                                  out_reg.extent_v != 4'd0))
        else $error("quad with zero extent");

    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !out_reg.quad_valid) |-> m_axis_tlast)
        else $error("result without quad is not last");

    a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("output word changed while stalled");

    a_mark_in_rect: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MARK) |-> (pu_reg >= su_reg && pv_reg >= sv_reg))
        else $error("mark cell outside the merged rectangle");

endmodule
